@@ rtl/stps_pkg.sv @@
package stps_pkg;

    localparam int FRAC_BITS = 20;
    localparam int DIV_W     = 2 * FRAC_BITS + 4;
    localparam int PROD_W    = 32 + FRAC_BITS;

    localparam logic [63:0] ONE_SQ  = 64'd1 << (2 * FRAC_BITS);
    localparam logic [41:0] T_LIMIT = 42'h0007FFFFFFF;

    localparam logic [2:0] REG_CENTER_X  = 3'd0;
    localparam logic [2:0] REG_CENTER_Y  = 3'd1;
    localparam logic [2:0] REG_CENTER_Z  = 3'd2;
    localparam logic [2:0] REG_RADIUS    = 3'd3;
    localparam logic [2:0] REG_HIT_EPS   = 3'd4;
    localparam logic [2:0] REG_START_T   = 3'd5;
    localparam logic [2:0] REG_DIFF_STEP = 3'd6;
    localparam logic [2:0] REG_MAX_STEPS = 3'd7;

    localparam logic [31:0] CZ_RST   = 32'(-(64'sd100 <<< FRAC_BITS));
    localparam logic [30:0] RAD_RST  = 31'(64'd50 << FRAC_BITS);
    localparam logic [20:0] EPS_RST  = 21'(((64'd1 << FRAC_BITS) + 64'd50) / 64'd100);
    localparam logic [20:0] T0_RST   = 21'(((64'd1 << FRAC_BITS) + 64'd500) / 64'd1000);
    localparam logic [9:0]  STEP_RST = 10'd100;

    typedef struct packed {
        logic signed [23:0] screen_x;
        logic signed [23:0] screen_y;
        logic [17:0]        pixel_tag;
    } t_pix_in;

    typedef struct packed {
        logic        hit;
        logic [23:0] color;
        logic [17:0] pixel_tag_out;
    } t_pix_out;

    typedef struct packed {
        logic signed [31:0] center_x;
        logic signed [31:0] center_y;
        logic signed [31:0] center_z;
        logic [30:0]        sphere_radius;
        logic [20:0]        hit_eps;
        logic [20:0]        start_t;
        logic [20:0]        diff_step;
        logic [9:0]         max_steps;
    } t_cfg;

endpackage

@@ rtl/stps_in_queue.sv @@
module stps_in_queue import stps_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_pix_in i_data,
    output logic    o_full,
    input  logic    i_pop,
    output logic    o_empty,
    output t_pix_in o_data
);
    t_pix_in    r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       w_wr, w_rd;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_wr) r_wp <= ~r_wp;
            if (w_rd) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(w_wr) - 2'(w_rd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) r_mem[r_wp] <= i_data;
    end
endmodule

@@ rtl/stps_out_queue.sv @@
module stps_out_queue import stps_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_pix_out i_data,
    output logic     o_full,
    input  logic     i_pop,
    output logic     o_empty,
    output t_pix_out o_data
);
    t_pix_out   r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       w_wr, w_rd;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_wr) r_wp <= ~r_wp;
            if (w_rd) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(w_wr) - 2'(w_rd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) r_mem[r_wp] <= i_data;
    end
endmodule

@@ rtl/stps_isqrt.sv @@
module stps_isqrt import stps_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_rad,
    output logic        o_done,
    output logic [31:0] o_root
);
    logic [63:0] r_n;
    logic [33:0] r_rem;
    logic [31:0] r_root;
    logic [4:0]  r_cnt;
    logic        r_busy, r_done;
    logic [35:0] w_cat, w_trial, n_rem;
    logic [31:0] n_root;

    // Two radicand bits per cycle, one root bit out.
    always_comb begin
        w_cat   = {r_rem, r_n[63:62]};
        w_trial = {2'b00, r_root, 2'b01};
        if (w_cat >= w_trial) begin
            n_rem  = w_cat - w_trial;
            n_root = {r_root[30:0], 1'b1};
        end else begin
            n_rem  = w_cat;
            n_root = {r_root[30:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 5'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'd0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_n    <= i_rad;
            r_rem  <= 34'd0;
            r_root <= 32'd0;
        end else if (r_busy) begin
            r_n    <= {r_n[61:0], 2'b00};
            r_rem  <= n_rem[33:0];
            r_root <= n_root;
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;
endmodule

@@ rtl/stps_div.sv @@
module stps_div import stps_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DIV_W-1:0] i_dvd,
    input  logic [31:0]      i_dvs,
    output logic             o_done,
    output logic [DIV_W-1:0] o_quo
);
    localparam int CNT_W = $clog2(DIV_W);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(DIV_W - 1);

    logic [DIV_W-1:0] r_q;
    logic [31:0]      r_rem, r_dvs;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy, r_done;
    logic [32:0]      w_cat, w_diff;
    logic             w_ge;

    // Restoring division, one quotient bit per cycle.
    assign w_cat  = {r_rem, r_q[DIV_W-1]};
    assign w_diff = w_cat - {1'b0, r_dvs};
    assign w_ge   = (w_cat >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dvd;
            r_rem <= 32'd0;
            r_dvs <= i_dvs;
        end else if (r_busy) begin
            r_q   <= {r_q[DIV_W-2:0], w_ge};
            r_rem <= w_ge ? w_diff[31:0] : w_cat[31:0];
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_q;
endmodule

@@ rtl/stps_core.sv @@
module stps_core import stps_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_cfg     i_cfg,
    input  logic     i_in_empty,
    input  t_pix_in  i_in_data,
    output logic     o_in_pop,
    input  logic     i_res_full,
    output logic     o_res_push,
    output t_pix_out o_res_data
);
    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_SQX   = 5'd1;
    localparam logic [4:0] S_SQY   = 5'd2;
    localparam logic [4:0] S_LEN   = 5'd3;
    localparam logic [4:0] S_LENW  = 5'd4;
    localparam logic [4:0] S_DIVS  = 5'd5;
    localparam logic [4:0] S_DIVW  = 5'd6;
    localparam logic [4:0] S_MCHK  = 5'd7;
    localparam logic [4:0] S_MMUL  = 5'd8;
    localparam logic [4:0] S_MSUB  = 5'd9;
    localparam logic [4:0] S_LMAG  = 5'd10;
    localparam logic [4:0] S_LSQ   = 5'd11;
    localparam logic [4:0] S_LSQRT = 5'd12;
    localparam logic [4:0] S_LWAIT = 5'd13;
    localparam logic [4:0] S_MEVAL = 5'd14;
    localparam logic [4:0] S_NSET  = 5'd15;
    localparam logic [4:0] S_NACC  = 5'd16;
    localparam logic [4:0] S_NSQ   = 5'd17;
    localparam logic [4:0] S_NSQRT = 5'd18;
    localparam logic [4:0] S_NWAIT = 5'd19;
    localparam logic [4:0] S_SHADE = 5'd20;
    localparam logic [4:0] S_SDIVW = 5'd21;
    localparam logic [4:0] S_DONE  = 5'd22;

    logic [4:0]                r_state;
    logic [17:0]               r_tag;
    logic signed [23:0]        r_x, r_y;
    logic [63:0]               r_acc;
    logic [31:0]               r_len;
    logic [FRAC_BITS:0]        r_umag [3];
    logic                      r_uneg [3];
    logic [1:0]                r_ax;
    logic [30:0]               r_t;
    logic [9:0]                r_iter;
    logic [PROD_W-1:0]         r_prod;
    logic signed [39:0]        r_d [3];
    logic signed [39:0]        r_lv [3];
    logic [31:0]               r_lm [3];
    logic                      r_lsh;
    logic [39:0]               r_lres;
    logic                      r_ret;
    logic [2:0]                r_nidx;
    logic signed [40:0]        r_g [3];
    logic signed [42:0]        r_s;
    logic [31:0]               r_nrm;
    logic [7:0]                r_shade;
    logic                      r_hit;

    logic [23:0]        w_xm, w_ym;
    logic [47:0]        w_sqx, w_sqy;
    logic               w_sq_start, w_sq_done;
    logic [31:0]        w_root;
    logic               w_div_start, w_div_done;
    logic [DIV_W-1:0]   w_dvd, w_quo;
    logic [31:0]        w_dvs;
    logic [39:0]        w_mag [3];
    logic [39:0]        w_max;
    logic               w_big;
    logic signed [39:0] w_cen;
    logic [31:0]        w_pm;
    logic signed [39:0] w_p;
    logic signed [40:0] w_dist0;
    logic [40:0]        w_dist;
    logic [41:0]        w_tnext;
    logic [40:0]        w_gm;
    logic [31:0]        w_gm32;
    logic signed [47:0] w_s10, w_s100, w_nrm;
    logic [1:0]         w_nj;
    logic signed [39:0] w_h;

    function automatic logic [39:0] mag40(input logic signed [39:0] v);
        mag40 = v[39] ? 40'(-v) : 40'(v);
    endfunction

    assign w_xm  = r_x[23] ? 24'(-r_x) : 24'(r_x);
    assign w_ym  = r_y[23] ? 24'(-r_y) : 24'(r_y);
    assign w_sqx = w_xm * w_xm;
    assign w_sqy = w_ym * w_ym;

    always_comb begin
        for (int i = 0; i < 3; i++) w_mag[i] = mag40(r_lv[i]);
        w_max = w_mag[0];
        if (w_mag[1] > w_max) w_max = w_mag[1];
        if (w_mag[2] > w_max) w_max = w_mag[2];
        w_big = (w_max >= 40'h0080000000);
    end

    always_comb begin
        case (r_ax)
            2'd0:    w_cen = 40'(i_cfg.center_x);
            2'd1:    w_cen = 40'(i_cfg.center_y);
            default: w_cen = 40'(i_cfg.center_z);
        endcase
    end

    // Point coordinate truncated toward zero, then offset by the center.
    assign w_pm    = r_prod[PROD_W-1:FRAC_BITS];
    assign w_p     = r_uneg[r_ax] ? -$signed({8'b0, w_pm}) : $signed({8'b0, w_pm});
    assign w_dist0 = $signed({10'b0, i_cfg.sphere_radius}) - $signed({1'b0, r_lres});
    assign w_dist  = w_dist0[40] ? 41'(-w_dist0) : 41'(w_dist0);
    assign w_tnext = {11'b0, r_t} + {1'b0, w_dist} + {21'b0, i_cfg.hit_eps};
    assign w_gm    = r_g[r_ax][40] ? 41'(-r_g[r_ax]) : 41'(r_g[r_ax]);
    assign w_gm32  = w_gm[31:0];
    assign w_s10   = 48'(r_s) * 48'sd10;
    assign w_s100  = 48'(r_s) * 48'sd100;
    assign w_nrm   = $signed({16'b0, r_nrm});
    assign w_nj    = r_nidx[2:1];
    assign w_h     = $signed({19'b0, i_cfg.diff_step});

    assign w_sq_start  = (r_state == S_LEN) || (r_state == S_LSQRT) || (r_state == S_NSQRT);
    assign w_div_start = (r_state == S_DIVS) ||
                         ((r_state == S_SHADE) && (r_nrm != 32'd0) &&
                          (w_s10 < w_nrm) && (w_s100 > w_nrm));
    assign w_dvs       = (r_state == S_SHADE) ? r_nrm : r_len;

    always_comb begin
        if (r_state == S_SHADE) begin
            w_dvd = DIV_W'(r_s) * DIV_W'(2550);
        end else begin
            case (r_ax)
                2'd0:    w_dvd = DIV_W'({w_xm, {FRAC_BITS{1'b0}}});
                2'd1:    w_dvd = DIV_W'({w_ym, {FRAC_BITS{1'b0}}});
                default: w_dvd = DIV_W'(ONE_SQ);
            endcase
        end
    end

    stps_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_sq_start),
        .i_rad   (r_acc),
        .o_done  (w_sq_done),
        .o_root  (w_root)
    );

    stps_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_dvd   (w_dvd),
        .i_dvs   (w_dvs),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

    assign o_in_pop   = (r_state == S_IDLE) && !i_in_empty;
    assign o_res_push = (r_state == S_DONE) && !i_res_full;
    assign o_res_data = '{hit: r_hit,
                          color: r_hit ? {r_shade, r_shade, r_shade} : 24'd0,
                          pixel_tag_out: r_tag};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE:  if (!i_in_empty) r_state <= S_SQX;
                S_SQX:   r_state <= S_SQY;
                S_SQY:   r_state <= S_LEN;
                S_LEN:   r_state <= S_LENW;
                S_LENW:  if (w_sq_done) r_state <= S_DIVS;
                S_DIVS:  r_state <= S_DIVW;
                S_DIVW:  if (w_div_done) r_state <= (r_ax == 2'd2) ? S_MCHK : S_DIVS;
                S_MCHK:  r_state <= (r_iter >= i_cfg.max_steps) ? S_DONE : S_MMUL;
                S_MMUL:  r_state <= S_MSUB;
                S_MSUB:  r_state <= (r_ax == 2'd2) ? S_LMAG : S_MMUL;
                S_LMAG:  r_state <= S_LSQ;
                S_LSQ:   if (r_ax == 2'd2) r_state <= S_LSQRT;
                S_LSQRT: r_state <= S_LWAIT;
                S_LWAIT: if (w_sq_done) r_state <= r_ret ? S_NACC : S_MEVAL;
                S_MEVAL: begin
                    if (w_dist < {20'b0, i_cfg.hit_eps}) r_state <= S_NSET;
                    else if (w_dist == {20'b0, i_cfg.hit_eps}) r_state <= S_DONE;
                    else if (w_tnext > T_LIMIT) r_state <= S_DONE;
                    else r_state <= S_MCHK;
                end
                S_NSET:  r_state <= S_LMAG;
                S_NACC:  r_state <= (r_nidx == 3'd5) ? S_NSQ : S_NSET;
                S_NSQ:   if (r_ax == 2'd2) r_state <= S_NSQRT;
                S_NSQRT: r_state <= S_NWAIT;
                S_NWAIT: if (w_sq_done) r_state <= S_SHADE;
                S_SHADE: r_state <= w_div_start ? S_SDIVW : S_DONE;
                S_SDIVW: if (w_div_done) r_state <= S_DONE;
                S_DONE:  if (!i_res_full) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_x   <= i_in_data.screen_x;
                r_y   <= i_in_data.screen_y;
                r_tag <= i_in_data.pixel_tag;
                r_hit <= 1'b0;
            end
            S_SQX: begin
                r_acc  <= {16'b0, w_sqx};
                r_t    <= {10'b0, i_cfg.start_t};
                r_iter <= 10'd1;
                r_ax   <= 2'd0;
            end
            S_SQY: r_acc <= r_acc + {16'b0, w_sqy} + ONE_SQ;
            S_LENW: if (w_sq_done) r_len <= w_root;
            S_DIVW: begin
                if (w_div_done) begin
                    r_umag[r_ax] <= w_quo[FRAC_BITS:0];
                    case (r_ax)
                        2'd0:    r_uneg[r_ax] <= r_x[23];
                        2'd1:    r_uneg[r_ax] <= r_y[23];
                        default: r_uneg[r_ax] <= 1'b1;
                    endcase
                    r_ax <= (r_ax == 2'd2) ? 2'd0 : r_ax + 2'd1;
                end
            end
            S_MCHK: r_ax <= 2'd0;
            S_MMUL: r_prod <= r_t * r_umag[r_ax];
            S_MSUB: begin
                r_d[r_ax]  <= w_p - w_cen;
                r_lv[r_ax] <= w_p - w_cen;
                r_ret      <= 1'b0;
                r_ax       <= (r_ax == 2'd2) ? 2'd0 : r_ax + 2'd1;
            end
            S_LMAG: begin
                // Shift large vectors down by two so the squares stay in range.
                for (int i = 0; i < 3; i++)
                    r_lm[i] <= w_big ? w_mag[i][33:2] : w_mag[i][31:0];
                r_lsh <= w_big;
                r_acc <= 64'd0;
                r_ax  <= 2'd0;
            end
            S_LSQ: begin
                r_acc <= r_acc + r_lm[r_ax] * r_lm[r_ax];
                r_ax  <= (r_ax == 2'd2) ? 2'd0 : r_ax + 2'd1;
            end
            S_LWAIT: if (w_sq_done) r_lres <= r_lsh ? {6'b0, w_root, 2'b00} : {8'b0, w_root};
            S_MEVAL: begin
                r_nidx <= 3'd0;
                if (w_dist < {20'b0, i_cfg.hit_eps}) r_hit <= 1'b1;
                r_t    <= w_tnext[30:0];
                r_iter <= r_iter + 10'd1;
            end
            S_NSET: begin
                // Offset one axis by the difference step, keep the others.
                for (int i = 0; i < 3; i++) begin
                    if (2'(i) == w_nj)
                        r_lv[i] <= r_nidx[0] ? r_d[i] - w_h : r_d[i] + w_h;
                    else
                        r_lv[i] <= r_d[i];
                end
                r_ret <= 1'b1;
            end
            S_NACC: begin
                if (r_nidx[0]) r_g[w_nj] <= r_g[w_nj] - $signed({1'b0, r_lres});
                else r_g[w_nj] <= $signed({1'b0, r_lres});
                r_nidx <= r_nidx + 3'd1;
                r_acc  <= 64'd0;
                r_ax   <= 2'd0;
            end
            S_NSQ: begin
                r_acc <= r_acc + w_gm32 * w_gm32;
                r_s   <= 43'(r_g[0]) + 43'(r_g[1]) + 43'(r_g[2]);
                r_ax  <= (r_ax == 2'd2) ? 2'd0 : r_ax + 2'd1;
            end
            S_NWAIT: if (w_sq_done) r_nrm <= w_root;
            S_SHADE: begin
                if (r_nrm == 32'd0) r_shade <= 8'd25;
                else if (w_s10 >= w_nrm) r_shade <= 8'd255;
                else r_shade <= 8'd25;
            end
            S_SDIVW: if (w_div_done) r_shade <= w_quo[7:0];
            default: ;
        endcase
    end
endmodule

@@ rtl/sphere_trace_pixel_shader.sv @@
// Channel   Direction  Handshake                   Payload
// pixel     in         push / full                 i_in  (t_pix_in)
// result    out        empty / pop                 o_out (t_pix_out)
// config    in         i_cfg_we, i_cfg_idx         i_cfg_data (32 bits)
//
// One pixel is in flight in the tracer at a time, two more wait in the input
// queue and two finished results in the output queue. A pixel goes through
// setup, march steps (one square root each) and the normal and shade; the
// serial square root and divider set the time that a pixel takes.
// Reset is synchronous, active low, and restores the register defaults.
module sphere_trace_pixel_shader import stps_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  t_pix_in     i_in,
    output logic        empty,
    input  logic        pop,
    output t_pix_out    o_out,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data
);
    t_cfg     r_cfg;
    logic     w_in_empty, w_in_pop, w_res_full, w_res_push;
    t_pix_in  w_in_data;
    t_pix_out w_res_data;

    // Hold the sphere and march settings; a write lands at once, so write only
    // while no pixel is in flight.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.center_x      <= 32'sd0;
            r_cfg.center_y      <= 32'sd0;
            r_cfg.center_z      <= CZ_RST;
            r_cfg.sphere_radius <= RAD_RST;
            r_cfg.hit_eps       <= EPS_RST;
            r_cfg.start_t       <= T0_RST;
            r_cfg.diff_step     <= T0_RST;
            r_cfg.max_steps     <= STEP_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_CENTER_X:  r_cfg.center_x      <= i_cfg_data;
                REG_CENTER_Y:  r_cfg.center_y      <= i_cfg_data;
                REG_CENTER_Z:  r_cfg.center_z      <= i_cfg_data;
                REG_RADIUS:    r_cfg.sphere_radius <= i_cfg_data[30:0];
                REG_HIT_EPS:   r_cfg.hit_eps       <= i_cfg_data[20:0];
                REG_START_T:   r_cfg.start_t       <= i_cfg_data[20:0];
                REG_DIFF_STEP: r_cfg.diff_step     <= i_cfg_data[20:0];
                REG_MAX_STEPS: r_cfg.max_steps     <= i_cfg_data[9:0];
                default: ;
            endcase
        end
    end

    // Front: accept pixels and hold them until the tracer is free.
    stps_in_queue u_in_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (i_in),
        .o_full  (full),
        .i_pop   (w_in_pop),
        .o_empty (w_in_empty),
        .o_data  (w_in_data)
    );

    // Back: direction, march, normal and shade.
    stps_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_in_empty (w_in_empty),
        .i_in_data  (w_in_data),
        .o_in_pop   (w_in_pop),
        .i_res_full (w_res_full),
        .o_res_push (w_res_push),
        .o_res_data (w_res_data)
    );

    // Results wait here until the consumer pops the transfer.
    stps_out_queue u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_data  (w_res_data),
        .o_full  (w_res_full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (o_out)
    );
endmodule
